[hdl/bthalloc_pkg.sv]
`default_nettype none
package bthalloc_pkg;
  localparam int HEAP_BYTES_DEF = 128;
  localparam int MIN_SPLIT = 3;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NO_FIT = 2'd1;
  localparam logic [1:0] ST_BAD    = 2'd2;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] payload_address;
    logic [7:0] read_data;
  } result_t;
endpackage
`default_nettype wire

[hdl/boundary_tag_heap_allocator_core.sv]
`default_nettype none
// Boundary-tag heap allocator over a HEAP_BYTES-byte heap held in one
// memory with one write port and one read port. After reset a clearing
// pass rebuilds the initial single free block; no request is taken
// meanwhile. Every request goes through a sequencer: read fetches the
// byte and returns it, write stores it; allocate walks block headers,
// then clears the payload one byte a cycle and writes the tags; free
// walks headers the same way, reads the next header, then clears the
// merged block one byte a cycle. A finished result moves to an output
// register, so the next request can start while it waits; a later result
// is held in the sequencer until the output register has been taken.
module boundary_tag_heap_allocator_core #(
  parameter int HEAP_BYTES = bthalloc_pkg::HEAP_BYTES_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire         cfg_wdata,
  input  wire         in_tvalid,
  output logic        in_tready,
  // mode[1:0], request_size[8:2], address[15:9], write_data[23:16]
  input  wire  [23:0] in_tdata,
  output logic        out_tvalid,
  input  wire         out_tready,
  // status[1:0], payload_address[8:2], read_data[16:9], zero[23:17]
  output logic [23:0] out_tdata
);
  import bthalloc_pkg::*;

  localparam int AW = $clog2(HEAP_BYTES);
  // Addresses and sums are held in 9 bits so h+s+1 never wraps.
  localparam int XW = 9;
  localparam logic [XW-1:0] HB = XW'(HEAP_BYTES);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_RDW   = 4'd3;
  localparam logic [3:0] S_WHDR  = 4'd4;
  localparam logic [3:0] S_WCHK  = 4'd5;
  localparam logic [3:0] S_ZERO  = 4'd6;
  localparam logic [3:0] S_TAG0  = 4'd7;
  localparam logic [3:0] S_TAG1  = 4'd8;
  localparam logic [3:0] S_TAG2  = 4'd9;
  localparam logic [3:0] S_TAG3  = 4'd10;
  localparam logic [3:0] S_NHDR  = 4'd11;
  localparam logic [3:0] S_NCHK  = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  logic [7:0] mem [HEAP_BYTES];
  logic [7:0] rdata_r;

  logic [3:0]    state_r, state_nxt;
  logic          policy_r;
  logic [1:0]    mode_r, mode_nxt;
  logic [6:0]    req_r, req_nxt;
  logic [XW-1:0] adr_r, adr_nxt;
  logic [7:0]    wd_r, wd_nxt;
  logic [XW-1:0] h_r, h_nxt;          // walk pointer
  logic [XW-1:0] ph_r, ph_nxt;        // previous header (free)
  logic          pfree_r, pfree_nxt;
  logic          found_r, found_nxt;
  logic [XW-1:0] bh_r, bh_nxt;        // chosen/start block
  logic [6:0]    bs_r, bs_nxt;        // chosen size
  logic [XW-1:0] end_r, end_nxt;      // footer position (free)
  logic [XW-1:0] ptr_r, ptr_nxt;      // clearing pointer
  logic          out_v_r, out_v_nxt;
  result_t       res_r, res_nxt;
  result_t       out_res_r, out_res_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdat;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdat;
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      policy_r <= 1'b0;
      out_v_r  <= 1'b0;
      ptr_r    <= '0;
    end else begin
      state_r <= state_nxt;
      out_v_r <= out_v_nxt;
      ptr_r   <= ptr_nxt;
      if (cfg_we) policy_r <= cfg_wdata;
    end
    mode_r <= mode_nxt; req_r <= req_nxt; adr_r <= adr_nxt; wd_r <= wd_nxt;
    h_r <= h_nxt; ph_r <= ph_nxt; pfree_r <= pfree_nxt; found_r <= found_nxt;
    bh_r <= bh_nxt; bs_r <= bs_nxt; end_r <= end_nxt; res_r <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, out_res_r.read_data, out_res_r.payload_address,
                       out_res_r.status};

  // Shared arithmetic on the header just read.
  logic [6:0]    s_rd;
  logic          a_rd;
  logic [XW-1:0] foot;
  logic          valid_h;
  logic [6:0]    gap;
  assign s_rd    = rdata_r[7:1];
  assign a_rd    = rdata_r[0];
  assign foot    = h_r + XW'(s_rd) + XW'(1);
  assign valid_h = (h_r < HB) && (foot < HB);
  assign gap     = bs_r - req_r;

  always_comb begin
    state_nxt = state_r; out_v_nxt = out_v_r; ptr_nxt = ptr_r;
    mode_nxt = mode_r; req_nxt = req_r; adr_nxt = adr_r; wd_nxt = wd_r;
    h_nxt = h_r; ph_nxt = ph_r; pfree_nxt = pfree_r; found_nxt = found_r;
    bh_nxt = bh_r; bs_nxt = bs_r; end_nxt = end_r; res_nxt = res_r;
    out_res_nxt = out_res_r;
    we = 1'b0; waddr = '0; wdat = '0; raddr = AW'(h_r);
    if (out_v_r && out_tready) out_v_nxt = 1'b0;
    unique case (state_r)
      S_CLR: begin
        we = 1'b1; waddr = AW'(ptr_r);
        wdat = (ptr_r == '0 || ptr_r == HB - XW'(1)) ?
               {7'(HEAP_BYTES - 2), 1'b0} : 8'd0;
        ptr_nxt = ptr_r + XW'(1);
        if (ptr_r == HB - XW'(1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          mode_nxt = in_tdata[1:0];
          req_nxt  = (in_tdata[8:2] == 7'd0) ? 7'd1 : in_tdata[8:2];
          adr_nxt  = XW'(in_tdata[15:9]);
          wd_nxt   = in_tdata[23:16];
          h_nxt = '0; pfree_nxt = 1'b0; found_nxt = 1'b0;
          res_nxt = '0;
          unique case (in_tdata[1:0])
            MODE_ALLOC: state_nxt = S_RD;
            MODE_FREE: begin
              if (in_tdata[15:9] == 7'd0 || XW'(in_tdata[15:9]) >= HB) begin
                res_nxt.status = ST_BAD; state_nxt = S_DONE;
              end else state_nxt = S_RD;
            end
            default: begin
              if (XW'(in_tdata[15:9]) >= HB) begin
                res_nxt.status = ST_BAD; state_nxt = S_DONE;
              end else if (in_tdata[1:0] == MODE_WRITE) begin
                state_nxt = S_WCHK; // reused as write slot
              end else begin
                // The byte is fetched now so that it is ready in S_RDW.
                raddr = AW'(in_tdata[15:9]);
                h_nxt = XW'(in_tdata[15:9]); state_nxt = S_RDW;
              end
            end
          endcase
        end
      end
      S_RD: begin
        // Header at h_r read into rdata_r for the next cycle.
        if (h_r >= HB) begin
          state_nxt = (mode_r == MODE_ALLOC) ? S_WHDR : S_WHDR;
        end else state_nxt = S_WHDR;
      end
      S_RDW: begin
        if (mode_r == MODE_READ) begin
          res_nxt.read_data = rdata_r;
        end
        state_nxt = S_DONE;
      end
      S_WCHK: begin
        we = 1'b1; waddr = AW'(adr_r); wdat = wd_r; state_nxt = S_DONE;
      end
      S_WHDR: begin
        if (mode_r == MODE_ALLOC) begin
          if (!valid_h) begin
            if (found_r) begin
              ptr_nxt = bh_r + XW'(1); state_nxt = S_ZERO;
            end else begin
              res_nxt.status = ST_NO_FIT; state_nxt = S_DONE;
            end
          end else begin
            if (!a_rd && s_rd >= req_r &&
                (!found_r || (policy_r && s_rd < bs_r))) begin
              found_nxt = 1'b1; bh_nxt = h_r; bs_nxt = s_rd;
            end
            if (!a_rd && s_rd >= req_r && !found_r && !policy_r) begin
              ptr_nxt = h_r + XW'(1); state_nxt = S_ZERO;
            end else begin
              h_nxt = foot + XW'(1); state_nxt = S_RD;
            end
          end
        end else begin
          if (!valid_h) begin
            res_nxt.status = ST_BAD; state_nxt = S_DONE;
          end else if (h_r == adr_r - XW'(1)) begin
            if (!a_rd) begin
              res_nxt.status = ST_BAD; state_nxt = S_DONE;
            end else begin
              bh_nxt  = pfree_r ? ph_r : h_r;
              end_nxt = foot;
              h_nxt   = foot + XW'(1);
              state_nxt = S_NHDR;
            end
          end else begin
            ph_nxt = h_r; pfree_nxt = !a_rd;
            h_nxt = foot + XW'(1); state_nxt = S_RD;
          end
        end
      end
      S_NHDR: state_nxt = S_NCHK;
      S_NCHK: begin
        if (valid_h && !a_rd) end_nxt = foot;
        ptr_nxt = bh_r + XW'(1);
        state_nxt = S_ZERO;
      end
      S_ZERO: begin
        if (mode_r == MODE_ALLOC) begin
          if (ptr_r > bh_r + XW'(bs_r)) state_nxt = S_TAG0;
          else begin
            we = 1'b1; waddr = AW'(ptr_r); ptr_nxt = ptr_r + XW'(1);
          end
        end else begin
          if (ptr_r >= end_r) state_nxt = S_TAG0;
          else begin
            we = 1'b1; waddr = AW'(ptr_r); ptr_nxt = ptr_r + XW'(1);
          end
        end
      end
      S_TAG0: begin
        we = 1'b1; waddr = AW'(bh_r); state_nxt = S_TAG1;
        if (mode_r == MODE_ALLOC)
          wdat = (gap >= 7'(MIN_SPLIT)) ? {req_r, 1'b1} : {bs_r, 1'b1};
        else wdat = {7'(end_r - bh_r - XW'(1)), 1'b0};
      end
      S_TAG1: begin
        we = 1'b1; state_nxt = S_TAG2;
        if (mode_r == MODE_ALLOC) begin
          if (gap >= 7'(MIN_SPLIT)) begin
            waddr = AW'(bh_r + XW'(req_r) + XW'(1)); wdat = {req_r, 1'b1};
          end else begin
            waddr = AW'(bh_r + XW'(bs_r) + XW'(1)); wdat = {bs_r, 1'b1};
            state_nxt = S_DONE;
          end
          res_nxt.payload_address = 7'(bh_r + XW'(1));
        end else begin
          waddr = AW'(end_r); wdat = {7'(end_r - bh_r - XW'(1)), 1'b0};
          state_nxt = S_DONE;
        end
      end
      S_TAG2: begin
        we = 1'b1; waddr = AW'(bh_r + XW'(req_r) + XW'(2));
        wdat = {gap - 7'd2, 1'b0}; state_nxt = S_TAG3;
      end
      S_TAG3: begin
        we = 1'b1; waddr = AW'(bh_r + XW'(bs_r) + XW'(1));
        wdat = {gap - 7'd2, 1'b0}; state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_v_r || out_tready) begin
          out_v_nxt = 1'b1; out_res_nxt = res_r; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire
